// ===== rtl/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/ffea_pkg.sv =====
package ffea_pkg;

  typedef struct packed {
    logic        used;
    logic        is_file;
    logic [11:0] start;
    logic [23:0] bytes;
  } ext_rec_t;

  typedef struct packed {
    logic     en;
    ext_rec_t rec;
  } tbl_wr_t;

endpackage

// ===== rtl/ffea_table.sv =====
module ffea_table
  import ffea_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int AW      = 6
) (
  input  logic          clk,
  input  tbl_wr_t       wr,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] rd_addr,
  output ext_rec_t      rd_data
);

  ext_rec_t mem [ENTRIES];
  ext_rec_t rd_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.rec;
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_r;

endmodule

// ===== rtl/first_fit_extent_allocator_top.sv =====
// Write transaction: no result. Query (unless the request is zero): clears the occupancy map,
// reads each table entry, marks the sectors of each file entry, then scans from the data start
// sector, the memory port of the occupancy map setting the pace; one item at a time.
// Reset (rst_n, synchronous) clears control state, sets the data start register to 1,
// then a clearing pass zeroes the table; no input taken on in_tdata.
module first_fit_extent_allocator_top
  import ffea_pkg::*;
#(
  parameter int SECTOR_BYTES  = 512,
  parameter int DISK_SECTORS  = 4096,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_index, entry_used, entry_is_file, entry_start, entry_bytes, request_bytes
  input  logic [71:0] in_tdata,
  // mode
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // first sector of the free run
  output logic [15:0] out_tdata,
  // found
  output logic [0:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int AW = (DISK_SECTORS > 1) ? $clog2(DISK_SECTORS) : 1;
  localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int RW = 25;
  localparam logic [CW-1:0] DISKC = CW'(DISK_SECTORS);
  localparam logic [RW-1:0] SB    = RW'(SECTOR_BYTES);
  localparam logic [TW-1:0] TLAST = TW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_CLR  = 3'd2;
  localparam logic [2:0] S_TRD  = 3'd3;
  localparam logic [2:0] S_TLD  = 3'd4;
  localparam logic [2:0] S_MARK = 3'd5;
  localparam logic [2:0] S_SCAN = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]    state_r;
  logic [11:0]   ds_r;
  logic [TW-1:0] ti_r;
  logic [CW-1:0] sc_r, psc_r, sec_r, cand_r;
  logic          pend_r;
  logic [23:0]   rem_r, req_r;
  logic [RW-1:0] rb_r;
  logic [11:0]   res_start_r;
  logic          res_found_r;
  logic          out_valid_r;
  logic [11:0]   out_start_r;
  logic          out_found_r;

  logic          in_acc;
  logic [5:0]    f_idx;
  ext_rec_t      f_rec;
  logic [23:0]   f_req;
  tbl_wr_t       tbl_wr;
  logic [TW-1:0] tbl_wa;
  ext_rec_t      tbl_rd;

  logic          map_we, map_wd, occ_q;
  logic [AW-1:0] map_wa, map_ra;
  logic          map_mem [DISK_SECTORS];

  logic [CW-1:0] cand_c;
  logic [RW-1:0] rb_c;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign f_idx         = in_tdata[5:0];
  assign f_rec.used    = in_tdata[6];
  assign f_rec.is_file = in_tdata[7];
  assign f_rec.start   = in_tdata[19:8];
  assign f_rec.bytes   = in_tdata[43:20];
  assign f_req         = in_tdata[67:44];

  always_comb begin
    tbl_wr.en  = 1'b0;
    tbl_wr.rec = f_rec;
    tbl_wa     = TW'(f_idx);
    if (state_r == S_INIT) begin
      tbl_wr.en  = 1'b1;
      tbl_wr.rec = '0;
      tbl_wa     = ti_r;
    end else if (in_acc && !in_tuser[0] && (32'(f_idx) < TABLE_ENTRIES)) begin
      tbl_wr.en = 1'b1;
    end
  end

  ffea_table #(.ENTRIES(TABLE_ENTRIES), .AW(TW)) u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .wr_addr (tbl_wa),
    .rd_addr (ti_r),
    .rd_data (tbl_rd)
  );

  always_comb begin
    map_we = 1'b0;
    map_wd = 1'b0;
    map_wa = sc_r[AW-1:0];
    if (state_r == S_CLR) begin
      map_we = 1'b1;
    end else if (state_r == S_MARK) begin
      map_we = 1'b1;
      map_wd = 1'b1;
      map_wa = sec_r[AW-1:0];
    end
  end

  assign map_ra = sc_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    occ_q <= map_mem[map_ra];
  end

  assign cand_c = (rb_r == '0) ? psc_r : cand_r;
  assign rb_c   = rb_r + SB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ds_r        <= 12'd1;
      ti_r        <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        ds_r <= cfg_data;
      end
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_INIT: begin
          ti_r <= ti_r + 1'b1;
          if (ti_r == TLAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && in_tuser[0]) begin
            req_r <= f_req;
            sc_r  <= '0;
            if (f_req == '0) begin
              res_start_r <= '0;
              res_found_r <= 1'b0;
              state_r     <= S_DONE;
            end else begin
              state_r <= S_CLR;
            end
          end
        end
        S_CLR: begin
          sc_r <= sc_r + 1'b1;
          if (sc_r == DISKC - 1'b1) begin
            ti_r    <= '0;
            state_r <= S_TRD;
          end
        end
        S_TRD: state_r <= S_TLD;
        S_TLD: begin
          if (tbl_rd.used && tbl_rd.is_file && (tbl_rd.bytes != '0) &&
              (CW'(tbl_rd.start) < DISKC)) begin
            sec_r   <= CW'(tbl_rd.start);
            rem_r   <= tbl_rd.bytes;
            state_r <= S_MARK;
          end else if (ti_r == TLAST) begin
            sc_r    <= CW'(ds_r);
            pend_r  <= 1'b0;
            rb_r    <= '0;
            state_r <= S_SCAN;
          end else begin
            ti_r    <= ti_r + 1'b1;
            state_r <= S_TRD;
          end
        end
        S_MARK: begin
          if ((RW'(rem_r) <= SB) || (sec_r == DISKC - 1'b1)) begin
            if (ti_r == TLAST) begin
              sc_r    <= CW'(ds_r);
              pend_r  <= 1'b0;
              rb_r    <= '0;
              state_r <= S_SCAN;
            end else begin
              ti_r    <= ti_r + 1'b1;
              state_r <= S_TRD;
            end
          end else begin
            sec_r <= sec_r + 1'b1;
            rem_r <= rem_r - SB[23:0];
          end
        end
        S_SCAN: begin
          if (sc_r < DISKC) begin
            pend_r <= 1'b1;
            psc_r  <= sc_r;
            sc_r   <= sc_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              res_start_r <= '0;
              res_found_r <= 1'b0;
              state_r     <= S_DONE;
            end
          end
          if (pend_r) begin
            if (!occ_q) begin
              cand_r <= cand_c;
              rb_r   <= rb_c;
              if (rb_c >= RW'(req_r)) begin
                res_start_r <= cand_c[11:0];
                res_found_r <= 1'b1;
                state_r     <= S_DONE;
              end
            end else begin
              rb_r <= '0;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_start_r <= res_start_r;
            out_found_r <= res_found_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_start_r};
  assign out_tuser  = out_found_r;

  `ASSERT_SAME(a_nf_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[11:0] == 12'd0, "not found with nonzero start")
  `ASSERT_SAME(a_mark_rng, clk, rst_n, state_r == S_MARK, sec_r < DISKC, "marking beyond disk end")
  `ASSERT_NEXT(a_done_out, clk, rst_n, (state_r == S_DONE) && (!out_valid_r || out_tready), out_tvalid && (state_r == S_IDLE), "result not presented")

endmodule
